[design/rrsw_pkg.sv]
// Shared types and constants for the round-robin scheduler wake-hint unit.
`timescale 1ns / 1ps

package rrsw_pkg;

  // Event codes carried on the operation field.
  localparam logic [2:0] OP_RESCHED    = 3'd0;
  localparam logic [2:0] OP_BLOCK      = 3'd1;
  localparam logic [2:0] OP_WAKE       = 3'd2;
  localparam logic [2:0] OP_SCHEDULE   = 3'd3;
  localparam logic [2:0] OP_SET_STATE  = 3'd4;
  localparam logic [2:0] OP_SET_CURR   = 3'd5;

  // Process state codes.
  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_DEAD    = 2'd3;

  // Field widths of the event and result items.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned PIDX_W  = 3;
  localparam int unsigned STATE_W = 2;
  localparam int unsigned COUNT_W = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // Capture the request and the registered search result.
    logic exec;  // Apply the captured request and load the result register.
  } cmd_t;

endpackage

[design/rrsw_ctrl.sv]
// Controller state machine that sequences each request through capture and execute.
`timescale 1ns / 1ps

module rrsw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rrsw_pkg::cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // A new request is taken only when the result register is free or being drained.
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state_r == S_EXEC);

  // Next state and result-valid flag.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/rrsw_datapath.sv]
// Datapath holding the process table, scheduler state, search logic and result register.
`timescale 1ns / 1ps

module rrsw_datapath #(
  parameter int unsigned PROCESS_COUNT = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rrsw_pkg::cmd_t                      cmd,
  input  logic [rrsw_pkg::OP_W-1:0]           in_operation,
  input  logic [rrsw_pkg::PIDX_W-1:0]         in_proc_index,
  input  logic [rrsw_pkg::STATE_W-1:0]        in_new_state,
  output logic                                out_switched,
  output logic [rrsw_pkg::PIDX_W-1:0]         out_prev_proc,
  output logic [rrsw_pkg::PIDX_W-1:0]         out_next_proc,
  output logic                                out_has_current,
  output logic [rrsw_pkg::COUNT_W-1:0]        out_switch_total
);

  // Slots beyond the addressable index range can never leave the dead state,
  // so only the addressable ones are stored and searched.
  localparam int unsigned MAX_ADDR = 1 << rrsw_pkg::PIDX_W;
  localparam int unsigned SLOTS    = (PROCESS_COUNT < MAX_ADDR) ? PROCESS_COUNT : MAX_ADDR;
  localparam int unsigned IW       = $clog2(SLOTS);
  localparam logic [rrsw_pkg::PIDX_W:0] SLOTS_CMP = (rrsw_pkg::PIDX_W + 1)'(SLOTS);
  localparam logic [IW:0]               SLOTS_W   = (IW + 1)'(SLOTS);

  // Scheduler state.
  logic [rrsw_pkg::STATE_W-1:0] states_r   [SLOTS];
  logic [rrsw_pkg::STATE_W-1:0] states_nxt [SLOTS];
  logic [IW-1:0]                cur_r, cur_nxt;
  logic                         cur_valid_r, cur_valid_nxt;
  logic                         pending_r, pending_nxt;
  logic [IW-1:0]                reader_r, reader_nxt;
  logic                         reader_valid_r, reader_valid_nxt;
  logic [IW-1:0]                hint_r, hint_nxt;
  logic                         hint_valid_r, hint_valid_nxt;
  logic [rrsw_pkg::COUNT_W-1:0] count_r, count_nxt;

  // Captured request and search result.
  logic [rrsw_pkg::OP_W-1:0]    op_r;
  logic [rrsw_pkg::PIDX_W-1:0]  idx_r;
  logic [rrsw_pkg::STATE_W-1:0] ns_r;
  logic                         found_r;
  logic [IW-1:0]                pick_r;

  // Result register.
  logic                         res_sw_r;
  logic [rrsw_pkg::PIDX_W-1:0]  res_prev_r;
  logic [rrsw_pkg::PIDX_W-1:0]  res_next_r;
  logic                         res_cur_valid_r;
  logic [rrsw_pkg::COUNT_W-1:0] res_count_r;

  logic                         rr_found;
  logic [IW-1:0]                rr_pick;
  logic                         hint_ok;
  logic                         do_run;
  logic                         idx_in_range;
  logic [IW-1:0]                idx_slot;

  // Rotating priority search: first runnable slot after the current one.
  // Walking the offsets downward leaves the nearest match in the result.
  always_comb begin
    logic [IW:0] cand;
    rr_found = 1'b0;
    rr_pick  = '0;
    for (int k = SLOTS - 1; k >= 1; k--) begin
      cand = {1'b0, cur_r} + (IW + 1)'(k);
      if (cand >= SLOTS_W) begin
        cand = cand - SLOTS_W;
      end
      if (!states_r[cand[IW-1:0]][1]) begin
        rr_found = 1'b1;
        rr_pick  = cand[IW-1:0];
      end
    end
  end

  // A valid, runnable hint other than the current process wins over the ring.
  assign hint_ok = hint_valid_r && (hint_r != cur_r) && !states_r[hint_r][1];

  // Capture the request together with the chosen successor.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      idx_r   <= in_proc_index;
      ns_r    <= in_new_state;
      found_r <= hint_ok || rr_found;
      pick_r  <= hint_ok ? hint_r : rr_pick;
    end
  end

  assign idx_in_range = ({1'b0, idx_r} < SLOTS_CMP);
  assign idx_slot     = idx_r[IW-1:0];

  // Apply the captured request.
  always_comb begin
    states_nxt       = states_r;
    cur_nxt          = cur_r;
    cur_valid_nxt    = cur_valid_r;
    pending_nxt      = pending_r;
    reader_nxt       = reader_r;
    reader_valid_nxt = reader_valid_r;
    hint_nxt         = hint_r;
    hint_valid_nxt   = hint_valid_r;
    do_run           = 1'b0;

    case (op_r)
      rrsw_pkg::OP_RESCHED: begin
        pending_nxt = 1'b1;
      end
      rrsw_pkg::OP_BLOCK: begin
        if (cur_valid_r) begin
          states_nxt[cur_r] = rrsw_pkg::ST_BLOCKED;
          reader_nxt        = cur_r;
          reader_valid_nxt  = 1'b1;
          do_run            = 1'b1;
        end
      end
      rrsw_pkg::OP_WAKE: begin
        if (reader_valid_r && (states_r[reader_r] == rrsw_pkg::ST_BLOCKED)) begin
          states_nxt[reader_r] = rrsw_pkg::ST_READY;
          reader_valid_nxt     = 1'b0;
          hint_nxt             = reader_r;
          hint_valid_nxt       = 1'b1;
          pending_nxt          = 1'b1;
        end
      end
      rrsw_pkg::OP_SCHEDULE: begin
        do_run = pending_r && cur_valid_r;
      end
      rrsw_pkg::OP_SET_STATE: begin
        if (idx_in_range) begin
          states_nxt[idx_slot] = ns_r;
        end
      end
      rrsw_pkg::OP_SET_CURR: begin
        if (idx_in_range) begin
          cur_nxt       = idx_slot;
          cur_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // A schedule run consumes the pending flag and the hint.
    if (do_run) begin
      pending_nxt    = 1'b0;
      hint_valid_nxt = 1'b0;
    end

    // The switch itself: demote a running predecessor, promote the successor.
    if (do_run && found_r) begin
      if (states_nxt[cur_r] == rrsw_pkg::ST_RUNNING) begin
        states_nxt[cur_r] = rrsw_pkg::ST_READY;
      end
      states_nxt[pick_r] = rrsw_pkg::ST_RUNNING;
      cur_nxt            = pick_r;
    end
  end

  // Count every switch.
  always_comb begin
    count_nxt = count_r;
    if (do_run && found_r) begin
      count_nxt = count_r + rrsw_pkg::COUNT_W'(1);
    end
  end

  // Scheduler state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        states_r[i] <= rrsw_pkg::ST_DEAD;
      end
      cur_r          <= '0;
      cur_valid_r    <= 1'b0;
      pending_r      <= 1'b0;
      reader_r       <= '0;
      reader_valid_r <= 1'b0;
      hint_r         <= '0;
      hint_valid_r   <= 1'b0;
      count_r        <= '0;
    end else if (cmd.exec) begin
      for (int i = 0; i < SLOTS; i++) begin
        states_r[i] <= states_nxt[i];
      end
      cur_r          <= cur_nxt;
      cur_valid_r    <= cur_valid_nxt;
      pending_r      <= pending_nxt;
      reader_r       <= reader_nxt;
      reader_valid_r <= reader_valid_nxt;
      hint_r         <= hint_nxt;
      hint_valid_r   <= hint_valid_nxt;
      count_r        <= count_nxt;
    end
  end

  // Result register, loaded as the request executes.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_sw_r        <= do_run && found_r;
      res_prev_r      <= rrsw_pkg::PIDX_W'(cur_r);
      res_next_r      <= rrsw_pkg::PIDX_W'(cur_nxt);
      res_cur_valid_r <= cur_valid_nxt;
      res_count_r     <= count_nxt;
    end
  end

  assign out_switched     = res_sw_r;
  assign out_prev_proc    = res_prev_r;
  assign out_next_proc    = res_next_r;
  assign out_has_current  = res_cur_valid_r;
  assign out_switch_total = res_count_r;

endmodule

[design/round_robin_scheduler_wake_hint_unit.sv]
// Top level of the round-robin scheduler wake-hint unit.
// Each request is one scheduler event and yields exactly one result. In the
// cycle a request is accepted the rotating priority search over the process
// table (at most eight slots) and the wake-hint check are registered, and in the
// next cycle the event is applied to the process table and the result register
// is loaded. The input is ready again once the controller is back in idle, as
// long as the result register is empty or being drained in the same cycle, so
// a request is not accepted until the previous one has executed. The process
// table is cleared to dead by reset; no clearing pass is needed.
`timescale 1ns / 1ps

module round_robin_scheduler_wake_hint_unit #(
  parameter int unsigned PROCESS_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rrsw_pkg::OP_W-1:0]     in_operation,
  input  logic [rrsw_pkg::PIDX_W-1:0]   in_proc_index,
  input  logic [rrsw_pkg::STATE_W-1:0]  in_new_state,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_switched,
  output logic [rrsw_pkg::PIDX_W-1:0]   out_prev_proc,
  output logic [rrsw_pkg::PIDX_W-1:0]   out_next_proc,
  output logic                          out_has_current,
  output logic [rrsw_pkg::COUNT_W-1:0]  out_switch_total
);

  rrsw_pkg::cmd_t cmd;

  // Sequencing of requests and the result handshake.
  rrsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Process table, scheduler state and result register.
  rrsw_datapath #(
    .PROCESS_COUNT (PROCESS_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_proc_index    (in_proc_index),
    .in_new_state     (in_new_state),
    .out_switched     (out_switched),
    .out_prev_proc    (out_prev_proc),
    .out_next_proc    (out_next_proc),
    .out_has_current  (out_has_current),
    .out_switch_total (out_switch_total)
  );

endmodule
